>>> design/atcs_pkg.sv
`timescale 1ns / 1ps

package atcs_pkg;

   // Geometry and constants
   localparam int ATCS_HISTORY_LEN = 20;

   localparam logic [7:0]  THR_RESET       = 8'd130;
   localparam logic [7:0]  THR_MAX         = 8'd255;
   localparam logic [8:0]  THR_RAISE       = 9'd5;
   localparam logic [2:0]  CORNER_TARGET   = 3'd4;
   localparam logic [15:0] MIN_HOLD_RESET  = 16'd200;
   localparam logic [7:0]  CONTRAST_RESET  = 8'd50;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_NUDGE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      PH_HOLD_INIT     = 3'd0,
      PH_LEARN_BG      = 3'd1,
      PH_SETTLE        = 3'd2,
      PH_SEARCH_BLOB   = 3'd3,
      PH_WAIT_CORNER   = 3'd4,
      PH_SEARCH_CORNER = 3'd5,
      PH_DONE          = 3'd6
   } phase_type;

   typedef enum logic [0:0] {
      CSR_MIN_HOLD        = 1'b0,
      CSR_CONTRAST_MARGIN = 1'b1
   } csr_index_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [31:0]        now_ms;
      logic [3:0]         blob_count;
      logic [2:0]         corner_blob_count;
      logic signed [4:0]  nudge_step;
   } item_type;

   typedef struct packed {
      logic [7:0]  thr;
      logic [7:0]  cal;
      phase_type   phase;
      logic        active;
      logic        fail;
      logic [31:0] hold_start;
   } state_type;

   typedef struct packed {
      logic learn;
      logic clear;
   } pulse_type;

   typedef struct packed {
      logic [15:0] min_hold_ms;
      logic [7:0]  contrast_margin;
   } cfg_type;

endpackage

>>> design/atcs_req_if.sv
`timescale 1ns / 1ps

interface atcs_req_if;
   import atcs_pkg::*;

   logic              valid;
   logic              ready;
   opcode_type        opcode;
   logic [31:0]       now_ms;
   logic [3:0]        blob_count;
   logic [2:0]        corner_blob_count;
   logic signed [4:0] nudge_step;

   modport source (
      output valid, opcode, now_ms, blob_count, corner_blob_count, nudge_step,
      input  ready
   );

   modport sink (
      input  valid, opcode, now_ms, blob_count, corner_blob_count, nudge_step,
      output ready
   );
endinterface

>>> design/atcs_rsp_if.sv
`timescale 1ns / 1ps

interface atcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] threshold_out;
   logic [2:0] phase_out;
   logic       calibrating;
   logic       contrast_failed;
   logic       learn_background;
   logic       clear_background;
   logic [7:0] calibrated_out;

   modport source (
      output valid, threshold_out, phase_out, calibrating, contrast_failed,
             learn_background, clear_background, calibrated_out,
      input  ready
   );

   modport sink (
      input  valid, threshold_out, phase_out, calibrating, contrast_failed,
             learn_background, clear_background, calibrated_out,
      output ready
   );
endinterface

>>> design/atcs_step.sv
`timescale 1ns / 1ps

module atcs_step #(
   parameter int HISTORY_LEN = atcs_pkg::ATCS_HISTORY_LEN
) (
   input  atcs_pkg::item_type        item,
   input  atcs_pkg::cfg_type         cfg,
   input  atcs_pkg::state_type       cur,
   input  logic [HISTORY_LEN-1:0]    hist_cur,
   output atcs_pkg::state_type       nxt,
   output logic [HISTORY_LEN-1:0]    hist_nxt,
   output atcs_pkg::pulse_type       pulse
);
   import atcs_pkg::*;

   logic [31:0]            elapsed;
   logic                   hold_ok;
   logic [7:0]             thr_lower;
   logic [8:0]             raise_sum;
   logic [7:0]             thr_raised;
   logic [9:0]             nudge_sum;
   logic [7:0]             thr_nudged;
   logic [HISTORY_LEN-1:0] hist_shift;
   logic                   corner_hit;

   // Shared arithmetic
   assign elapsed    = item.now_ms - cur.hold_start;
   assign hold_ok    = elapsed > {16'd0, cfg.min_hold_ms};
   assign thr_lower  = (cur.thr == 8'd0) ? 8'd0 : cur.thr - 8'd1;
   assign raise_sum  = {1'b0, cur.thr} + THR_RAISE;
   assign thr_raised = raise_sum[8] ? THR_MAX : raise_sum[7:0];
   assign nudge_sum  = {2'b00, cur.thr} + {{5{item.nudge_step[4]}}, item.nudge_step};
   assign thr_nudged = nudge_sum[9] ? 8'd0 : (nudge_sum[8] ? THR_MAX : nudge_sum[7:0]);
   assign hist_shift = hist_cur << 1;
   assign corner_hit = item.corner_blob_count == CORNER_TARGET;

   // Next state
   always_comb begin
      nxt      = cur;
      hist_nxt = hist_cur;
      case (item.opcode)
         OP_START: begin
            nxt.active     = 1'b1;
            nxt.hold_start = item.now_ms;
         end
         OP_STOP: begin
            nxt.thr    = cur.cal;
            nxt.phase  = PH_HOLD_INIT;
            nxt.active = 1'b0;
         end
         OP_NUDGE: begin
            nxt.thr = thr_nudged;
         end
         default: begin
            if (cur.active) begin
               case (cur.phase)
                  PH_HOLD_INIT: begin
                     if (hold_ok) begin
                        nxt.phase      = PH_LEARN_BG;
                        nxt.hold_start = item.now_ms;
                        nxt.fail       = 1'b0;
                     end
                  end
                  PH_LEARN_BG: begin
                     if (hold_ok) begin
                        nxt.phase      = PH_SETTLE;
                        nxt.hold_start = item.now_ms;
                        nxt.thr        = THR_MAX;
                     end
                  end
                  PH_SETTLE: begin
                     if (hold_ok) begin
                        nxt.phase      = PH_SEARCH_BLOB;
                        nxt.hold_start = item.now_ms;
                     end
                  end
                  PH_SEARCH_BLOB: begin
                     if (item.blob_count == 4'd0) begin
                        nxt.thr = thr_lower;
                     end else begin
                        nxt.thr        = thr_raised;
                        nxt.cal        = thr_raised;
                        nxt.phase      = PH_WAIT_CORNER;
                        nxt.hold_start = item.now_ms;
                        if (thr_raised > ~cfg.contrast_margin) begin
                           nxt.fail = 1'b1;
                        end
                     end
                  end
                  PH_WAIT_CORNER: begin
                     if (hold_ok) begin
                        nxt.phase      = PH_SEARCH_CORNER;
                        nxt.hold_start = item.now_ms;
                        hist_nxt       = '0;
                     end
                  end
                  PH_SEARCH_CORNER: begin
                     hist_nxt = hist_shift | HISTORY_LEN'(corner_hit);
                     if (corner_hit && (&(hist_shift | HISTORY_LEN'(1'b1)))) begin
                        nxt.phase      = PH_DONE;
                        nxt.hold_start = item.now_ms;
                     end else begin
                        nxt.thr = thr_lower;
                     end
                  end
                  PH_DONE: begin
                     if (hold_ok) begin
                        nxt.hold_start = item.now_ms;
                     end
                  end
                  default: begin
                     nxt.thr    = cur.cal;
                     nxt.phase  = PH_HOLD_INIT;
                     nxt.active = 1'b0;
                  end
               endcase
            end
         end
      endcase
   end

   // Request pulses
   always_comb begin
      pulse = '0;
      case (item.opcode)
         OP_START, OP_STOP: begin
            pulse.clear = 1'b1;
         end
         OP_TICK: begin
            if (cur.active) begin
               case (cur.phase)
                  PH_HOLD_INIT:     pulse.learn = hold_ok;
                  PH_LEARN_BG, PH_SETTLE, PH_SEARCH_BLOB, PH_WAIT_CORNER,
                  PH_SEARCH_CORNER, PH_DONE: pulse = '0;
                  default:          pulse.clear = 1'b1;
               endcase
            end
         end
         default: begin
            pulse = '0;
         end
      endcase
   end

endmodule

>>> design/auto_threshold_calibration_sequencer.sv
`timescale 1ns / 1ps
// An accepted req item goes through the input register and then the result register to rsp.
// Throughput: 1 item per cycle while rsp_chan.ready is high; the per-item update of the phase,
//   threshold, timer and hit window is one pass of logic between the input and result registers.
// Reset: synchronous, active high; threshold 130, phase 0, idle, flags and history cleared,
//   min_hold_ms 200, contrast_margin 50, both pipeline stages empty.

module auto_threshold_calibration_sequencer #(
   parameter int HISTORY_LEN = atcs_pkg::ATCS_HISTORY_LEN
) (
   input  logic                        clock,
   input  logic                        reset,
   atcs_req_if.sink                    req_chan,
   atcs_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  atcs_pkg::csr_index_type     csr_index,
   input  logic [15:0]                 csr_wr_data
);
   import atcs_pkg::*;

   // Configuration registers
   cfg_type                cfg_ff;

   // Input stage
   logic                   in_valid_ff;
   item_type               in_item_ff;

   // Sequencer state
   state_type              state_ff;
   state_type              state_in;
   logic [HISTORY_LEN-1:0] hist_ff;
   logic [HISTORY_LEN-1:0] hist_in;
   pulse_type              pulse;

   // Result stage
   logic                   out_valid_ff;
   state_type              out_state_ff;
   pulse_type              out_pulse_ff;

   logic                   req_fire;
   logic                   step_fire;

   // Move the held item into the result register when that register is free or being drained.
   assign step_fire      = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   // Take a new item whenever the input register is empty or empties this cycle.
   assign req_chan.ready = !in_valid_ff || step_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_hold_ms     <= MIN_HOLD_RESET;
         cfg_ff.contrast_margin <= CONTRAST_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_HOLD:        cfg_ff.min_hold_ms     <= csr_wr_data;
            CSR_CONTRAST_MARGIN: cfg_ff.contrast_margin <= csr_wr_data[7:0];
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   // Input register: hold the item until the step logic takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.opcode            <= req_chan.opcode;
         in_item_ff.now_ms            <= req_chan.now_ms;
         in_item_ff.blob_count        <= req_chan.blob_count;
         in_item_ff.corner_blob_count <= req_chan.corner_blob_count;
         in_item_ff.nudge_step        <= req_chan.nudge_step;
      end
   end

   // Per-item update of phase, threshold, timer and corner hit window.
   atcs_step #(
      .HISTORY_LEN (HISTORY_LEN)
   ) u_step (
      .item     (in_item_ff),
      .cfg      (cfg_ff),
      .cur      (state_ff),
      .hist_cur (hist_ff),
      .nxt      (state_in),
      .hist_nxt (hist_in),
      .pulse    (pulse)
   );

   // Commit state only when the item advances, so stalls never double-apply an update.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.thr        <= THR_RESET;
         state_ff.cal        <= 8'd0;
         state_ff.phase      <= PH_HOLD_INIT;
         state_ff.active     <= 1'b0;
         state_ff.fail       <= 1'b0;
         state_ff.hold_start <= 32'd0;
         hist_ff             <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
         hist_ff  <= hist_in;
      end
   end

   // Result register: a finished item waits here while the next one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         out_state_ff <= state_in;
         out_pulse_ff <= pulse;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.threshold_out    = out_state_ff.thr;
   assign rsp_chan.phase_out        = out_state_ff.phase;
   assign rsp_chan.calibrating      = out_state_ff.active;
   assign rsp_chan.contrast_failed  = out_state_ff.fail;
   assign rsp_chan.learn_background = out_pulse_ff.learn;
   assign rsp_chan.clear_background = out_pulse_ff.clear;
   assign rsp_chan.calibrated_out   = out_state_ff.cal;

   // A nonzero phase only exists while the sequence is armed.
   a_phase_implies_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase != PH_HOLD_INIT) |-> state_ff.active)
      else $error("phase left nonzero while sequence inactive");

   // A background capture request is reported together with entry to the capture phase.
   a_learn_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.learn_background) |->
      (rsp_chan.phase_out == PH_LEARN_BG) && rsp_chan.calibrating)
      else $error("background capture request outside capture phase");

   // Sequencer state changes only when an item passes the step logic.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !step_fire |=> $stable(state_ff) && $stable(hist_ff))
      else $error("state changed without an item");

endmodule
